[rtl/lfu_pkg.sv]
// lfu_pkg: sizes, operation codes and the controller-to-datapath command bundle
// for the lfu cache with lru tie-break; no dependencies
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 31;
	localparam int CAP_W      = 5;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

	// victim sort key: {invalid, count, inverted rank}, smallest wins
	localparam int SKEY_W  = 1 + COUNT_BITS + RANK_W;
	localparam int GRP_SZ  = 4;
	localparam int GROUPS  = (ENTRIES + GRP_SZ - 1) / GRP_SZ;

	localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [RANK_W-1:0]     rank_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SKEY_W-1:0]     skey_t;

	typedef struct packed {
		logic load;    // capture an input beat
		logic match;   // key match and first victim stage
		logic select;  // final victim stage
		logic commit;  // apply the update and load the result
		logic cfg_wr;  // write capacity register
	} cmd_t;

endpackage

[rtl/lfu_cache_lru_tiebreak.sv]
// lfu_cache_lru_tiebreak: top level of the lfu key-value cache with lru tie-break
// depends on lfu_pkg, lfu_ctrl, lfu_dpath (which holds lfu_victim)
//
// sixteen-entry key-value cache. a get (mode 0) returns the stored value on a
// hit and counts a use; a put (mode 1) updates a present key or inserts a new
// one with count 1. when the fill has reached capacity_in_use, a new key first
// evicts the entry with the lowest use count, the least recent one among equal
// counts, and reports its key. a capacity of zero makes puts do nothing, gets
// still find what was kept. use counts saturate at their width. every input
// beat yields exactly one result beat. items are handled one at a time in four
// steps (capture, key match with the first victim tree stage, final victim
// stage, update): the result beat is registered at the end of the update step,
// and no new input beat is taken until the last item has left its update step;
// the result then sits in an output register and the next item is
// accepted while it waits, that item then holds in its update step until the
// waiting beat leaves. the capacity register may be written at any cycle while
// the block is idle and resets to 16; values above 16 act as 16.
module lfu_cache_lru_tiebreak import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] store_value,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key,
	// capacity register write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	// command bundle from the sequencer to the datapath
	cmd_t cmd;

	// sequencer: handshakes and step timing
	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// datapath: entries, match, victim tree, update and result beat
	lfu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

[rtl/lfu_ctrl.sv]
// lfu_ctrl: sequencer for the lfu cache, one item at a time through match,
// select and update; owns all three handshakes. depends on lfu_pkg
module lfu_ctrl import lfu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_valid,
	output logic cfg_ready,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_SELECT = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_blocked;

	assign out_blocked = out_valid_q && out_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cfg_ready   = 1'b1;

	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.match  = (state_q == ST_MATCH);
	assign cmd.select = (state_q == ST_SELECT);
	assign cmd.commit = (state_q == ST_UPDATE) && !out_blocked;
	assign cmd.cfg_wr = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MATCH;
				end
				ST_MATCH:  state_q <= ST_SELECT;
				ST_SELECT: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (!out_blocked) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/lfu_victim.sv]
// lfu_victim: two-stage registered minimum tree picking the lowest-count,
// least-recent valid entry. depends on lfu_pkg
module lfu_victim import lfu_pkg::*; (
	input  logic   clk,
	input  cmd_t   cmd,
	input  logic   valid [ENTRIES],
	input  count_t count [ENTRIES],
	input  rank_t  rank  [ENTRIES],
	output idx_t   victim_idx
);

	skey_t skey       [ENTRIES];
	skey_t grp_key_s1 [GROUPS];
	idx_t  grp_idx_s1 [GROUPS];
	skey_t grp_key    [GROUPS];
	idx_t  grp_idx    [GROUPS];
	skey_t best_key;
	idx_t  best_idx;
	idx_t  victim_idx_q;

	always_comb begin
		for (int n = 0; n < ENTRIES; n++) begin
			skey[n] = {~valid[n], count[n], ~rank[n]};
		end
	end

	// first stage: best of each group of four
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_key[g] = '1;
			grp_idx[g] = IDX_W'(g * GRP_SZ);
			for (int j = 0; j < GRP_SZ; j++) begin
				if ((g * GRP_SZ + j) < ENTRIES) begin
					if (skey[g * GRP_SZ + j] < grp_key[g]) begin
						grp_key[g] = skey[g * GRP_SZ + j];
						grp_idx[g] = IDX_W'(g * GRP_SZ + j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			grp_key_s1 <= grp_key;
			grp_idx_s1 <= grp_idx;
		end
	end

	// second stage: best over the groups
	always_comb begin
		best_key = '1;
		best_idx = grp_idx_s1[0];
		for (int g = 0; g < GROUPS; g++) begin
			if (grp_key_s1[g] < best_key) begin
				best_key = grp_key_s1[g];
				best_idx = grp_idx_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.select) victim_idx_q <= best_idx;
	end

	assign victim_idx = victim_idx_q;

endmodule

[rtl/lfu_dpath.sv]
// lfu_dpath: entry storage, parallel key match, count/rank update and result
// register for the lfu cache. depends on lfu_pkg and lfu_victim
module lfu_dpath import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic             mode,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] store_value,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key
);

	logic             valid_q [ENTRIES];
	logic [KEY_W-1:0] key_q   [ENTRIES];
	logic [VAL_W-1:0] value_q [ENTRIES];
	count_t           count_q [ENTRIES];
	rank_t            rank_q  [ENTRIES];
	logic [FILL_W-1:0] fill_q;
	logic [CAP_W-1:0]  cap_q;

	logic             mode_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] val_s1;
	logic             hit_s2;
	idx_t             hit_idx_s2;

	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evicted_key_q;

	idx_t             victim_idx;
	logic             match_any;
	idx_t             match_idx;
	logic [CMP_W-1:0] cap_eff;
	logic             cap_nz;
	logic             do_touch;
	logic             do_insert;
	logic             do_evict;
	rank_t            hit_rank;
	rank_t            vic_rank;
	logic             valid_rm [ENTRIES];
	logic             slot_found;
	idx_t             slot;

	lfu_victim u_victim (
		.clk        (clk),
		.cmd        (cmd),
		.valid      (valid_q),
		.count      (count_q),
		.rank       (rank_q),
		.victim_idx (victim_idx)
	);

	// capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1 <= mode;
			key_s1  <= lookup_key;
			val_s1  <= store_value;
		end
	end

	// parallel key match, lowest index wins
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key_s1) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_s2     <= match_any;
			hit_idx_s2 <= match_idx;
		end
	end

	// decide the operation
	always_comb begin
		cap_eff   = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
		cap_nz    = (cap_q != '0);
		do_touch  = hit_s2 && (mode_s1 == MODE_GET || cap_nz);
		do_insert = (mode_s1 == MODE_PUT) && !hit_s2 && cap_nz;
		do_evict  = do_insert && (CMP_W'(fill_q) >= cap_eff);
		hit_rank  = rank_q[hit_idx_s2];
		vic_rank  = rank_q[victim_idx];
	end

	// valid bits after removal and the first free slot
	always_comb begin
		slot_found = 1'b0;
		slot       = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			valid_rm[i] = valid_q[i] && !(do_evict && victim_idx == IDX_W'(i));
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_rm[i]) begin
				slot_found = 1'b1;
				slot       = IDX_W'(i);
			end
		end
	end

	// control state: valid bits, fill level, capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
			fill_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cmd.cfg_wr) cap_q <= cfg_data;
			if (cmd.commit && do_insert) begin
				for (int i = 0; i < ENTRIES; i++) begin
					valid_q[i] <= valid_rm[i] || (slot_found && slot == IDX_W'(i));
				end
				if (slot_found) begin
					fill_q <= do_evict ? fill_q : fill_q + FILL_W'(1);
				end else if (do_evict) begin
					fill_q <= fill_q - FILL_W'(1);
				end
			end
		end
	end

	// entry payload update
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_touch) begin
					if (hit_idx_s2 == IDX_W'(i)) begin
						rank_q[i] <= '0;
						if (count_q[i] != COUNT_MAX) count_q[i] <= count_q[i] + COUNT_BITS'(1);
						if (mode_s1 == MODE_PUT) value_q[i] <= val_s1;
					end else if (valid_q[i] && rank_q[i] < hit_rank) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end else if (do_insert) begin
					if (slot_found && slot == IDX_W'(i)) begin
						key_q[i]   <= key_s1;
						value_q[i] <= val_s1;
						count_q[i] <= COUNT_BITS'(1);
						rank_q[i]  <= '0;
					end else if (valid_rm[i]) begin
						// removal closes the gap above the victim, insertion pushes all down
						if (!(do_evict && rank_q[i] > vic_rank)) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q         <= hit_s2;
			read_value_q  <= (mode_s1 == MODE_GET && hit_s2) ? value_q[hit_idx_s2] : '0;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? key_q[victim_idx] : '0;
		end
	end

	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule
